// File: sv/normalized_xcorr_peak_lag_core_assert.svh
// assertion macros shared by the correlation peak search modules
`ifndef NORMALIZED_XCORR_PEAK_LAG_CORE_ASSERT_SVH
`define NORMALIZED_XCORR_PEAK_LAG_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define NXCPL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define NXCPL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/nxcpl_pkg.sv
// types and constants of the correlation peak search
package nxcpl_pkg;

  localparam int ACC_W   = 64;
  localparam int ROOT_W  = 32;
  localparam int LAG_W   = 12;
  localparam int COEF_W  = 16;
  localparam int OUT_W   = 32;
  localparam int Q_SHIFT = 15;
  localparam int CNT_W   = 6;

  localparam logic [COEF_W-1:0] COEF_MAX = 16'h7FFF;
  localparam logic [COEF_W-1:0] COEF_MIN = 16'h8000;

  localparam logic CMD_TEMPLATE = 1'b0;
  localparam logic CMD_TRACE    = 1'b1;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } nxcpl_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_MAC,
    S_MUL_A1,
    S_MUL_A2,
    S_SQRT,
    S_MUL_N1,
    S_MUL_N2,
    S_DIV1,
    S_DIV2,
    S_CMP,
    S_EMIT
  } nxcpl_state_t;

  typedef struct packed {
    logic             start;
    nxcpl_op_t        op;
    logic             neg;
    logic [ACC_W-1:0] x;
    logic [ACC_W-1:0] y;
  } nxcpl_req_t;

  typedef struct packed {
    logic             done;
    logic [ACC_W-1:0] result;
  } nxcpl_rsp_t;

endpackage

// File: sv/nxcpl_iter_unit.sv
// shared iterative unit: shift-add multiply, restoring divide, integer square root
module nxcpl_iter_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  nxcpl_pkg::nxcpl_req_t req,
  output nxcpl_pkg::nxcpl_rsp_t rsp
);

  localparam int W = nxcpl_pkg::ACC_W;

  logic                       busy;
  logic                       done;
  nxcpl_pkg::nxcpl_op_t       op;
  logic                       neg;
  logic [nxcpl_pkg::CNT_W-1:0] cnt;
  logic [W-1:0]               acc;
  logic [W-1:0]               xa;
  logic [W-1:0]               yb;
  logic [W-1:0]               rem;
  logic [W-1:0]               result;

  logic [W:0]   rem_sh;
  logic         div_ge;
  logic [W-1:0] div_acc;
  logic [W-1:0] sq_sum;
  logic         sq_ge;
  logic [W-1:0] sq_acc;

  always_comb begin
    rem_sh  = {rem, xa[W-1]};
    div_ge  = (rem_sh >= {1'b0, yb});
    div_acc = {acc[W-2:0], div_ge};
    sq_sum  = acc + yb;
    sq_ge   = (xa >= sq_sum);
    sq_acc  = sq_ge ? ((acc >> 1) + yb) : (acc >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy) begin
        unique case (op)
          nxcpl_pkg::OP_MUL: begin
            if (yb == '0) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
          nxcpl_pkg::OP_DIV, nxcpl_pkg::OP_SQRT: begin
            if ((op == nxcpl_pkg::OP_DIV && cnt == nxcpl_pkg::CNT_W'(W - 1)) ||
                (op == nxcpl_pkg::OP_SQRT && cnt == nxcpl_pkg::CNT_W'(W / 2 - 1))) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
          default: busy <= 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op  <= req.op;
      neg <= req.neg;
      cnt <= '0;
      acc <= '0;
      rem <= '0;
      xa  <= req.x;
      yb  <= (req.op == nxcpl_pkg::OP_SQRT) ? (W'(1) << (W - 2)) : req.y;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      unique case (op)
        nxcpl_pkg::OP_MUL: begin
          if (yb == '0) begin
            result <= neg ? (W'(0) - acc) : acc;
          end else begin
            if (yb[0]) acc <= acc + xa;
            xa <= xa << 1;
            yb <= yb >> 1;
          end
        end
        nxcpl_pkg::OP_DIV: begin
          rem    <= div_ge ? W'(rem_sh - {1'b0, yb}) : rem_sh[W-1:0];
          acc    <= div_acc;
          xa     <= xa << 1;
          result <= div_acc;
        end
        nxcpl_pkg::OP_SQRT: begin
          if (sq_ge) xa <= xa - sq_sum;
          acc    <= sq_acc;
          yb     <= yb >> 2;
          result <= sq_acc;
        end
        default: acc <= acc;
      endcase
    end
  end

  assign rsp.done   = done;
  assign rsp.result = result;

  `include "normalized_xcorr_peak_lag_core_assert.svh"

  `NXCPL_ASSERT_IMP(a_start_free, req.start, !busy, "unit started while busy")
  `NXCPL_ASSERT_NXT(a_start_busy, req.start, busy, "unit did not take a start")
  `NXCPL_ASSERT_IMP(a_done_idle, done, !busy, "done raised while still iterating")

endmodule

// File: sv/normalized_xcorr_peak_lag_core.sv
// normalized cross-correlation peak search over a stored template and trace
// a template beat or a non-final trace beat is stored; a final trace beat starts a
// search: template sums and the template norm, then per lag multiply-accumulate sums,
// shift-add multiplies, 32 root steps and up to 128 divide steps on the one shared unit
// s_tready and cfg_ready are low during a search; sync active-high reset clears counts and flags
module normalized_xcorr_peak_lag_core #(
  parameter int TEMPLATE_MAX = 256,
  parameter int TRACE_MAX    = 4096,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_tdata,  // sample
  input  logic                                   s_tuser,  // command
  input  logic                                   s_tlast,  // last
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [nxcpl_pkg::OUT_W-1:0]            m_tdata,  // best_lag, best_coeff
  output logic                                   m_tuser,  // overflow
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic                                   cfg_data  // allow_anti
);

  localparam int W    = nxcpl_pkg::ACC_W;
  localparam int TCW  = $clog2(TEMPLATE_MAX + 1);
  localparam int RCW  = $clog2(TRACE_MAX + 1);
  localparam int TAW  = $clog2(TEMPLATE_MAX);
  localparam int RAW  = $clog2(TRACE_MAX);
  localparam int AW   = ((RCW > TCW) ? RCW : TCW) + 1;
  localparam int SDW  = SAMPLE_BITS + TCW;
  localparam int PW   = 2 * SAMPLE_BITS;
  localparam int RW   = nxcpl_pkg::ROOT_W;
  localparam int CW   = nxcpl_pkg::COEF_W;

  nxcpl_pkg::nxcpl_state_t state, state_next;
  nxcpl_pkg::nxcpl_req_t   req;
  nxcpl_pkg::nxcpl_rsp_t   rsp;

  logic [SAMPLE_BITS-1:0] tmpl_mem [TEMPLATE_MAX];
  logic [SAMPLE_BITS-1:0] trace_mem [TRACE_MAX];
  logic [SAMPLE_BITS-1:0] tmpl_q, trace_q;

  logic            allow_anti;
  logic [TCW-1:0]  template_count;
  logic [RCW-1:0]  trace_count;
  logic            template_done;
  logic            overflow_flag;
  logic            launched;
  logic            pre;
  logic [TCW-1:0]  it;
  logic            v1, v2;
  logic [RCW-1:0]  lag, lag_end;

  logic signed [SAMPLE_BITS-1:0] d_s;
  logic signed [PW-1:0]          p_dd, p_dr;
  logic signed [SAMPLE_BITS-1:0] d2;
  logic signed [SDW-1:0]         sd, sr;
  logic [W-1:0]                  sdd, sdr, tmp, a_val, num;
  logic [RW-1:0]                 sa, sb;
  logic [W-1:0]                  q_val;
  logic                          zero_c;
  logic signed [CW-1:0]          best;
  logic [RCW-1:0]                best_lag;

  logic                 in_fire;
  logic [TCW-1:0]       tc_eff;
  logic                 issue;
  logic                 mac_done;
  logic                 mac_clear;
  logic                 can_search;
  logic                 emit_go;
  logic                 last_lag;
  logic [AW-1:0]        trace_addr;
  logic [W-1:0]         sd64, sr64, sd_mag, n64, num_mag;
  logic signed [CW-1:0] coef;
  logic [CW:0]          abs_c, abs_best;
  logic                 better;

  assign cfg_ready = (state == nxcpl_pkg::S_IDLE);
  assign in_fire   = s_tvalid && s_tready;
  assign tc_eff    = template_done ? '0 : template_count;
  assign issue     = (state == nxcpl_pkg::S_MAC) && (it != template_count);
  assign mac_done  = (it == template_count) && !v1 && !v2;
  assign trace_addr = AW'(lag) + AW'(it);
  assign can_search = template_done && (template_count != '0) &&
                      (AW'(trace_count) > AW'(template_count));
  assign emit_go   = (state == nxcpl_pkg::S_EMIT) && (!m_tvalid || m_tready);
  assign last_lag  = ((lag + 1'b1) == lag_end);
  assign mac_clear = (state == nxcpl_pkg::S_START) ||
                     (state == nxcpl_pkg::S_SQRT && rsp.done && pre) ||
                     (state == nxcpl_pkg::S_CMP && !last_lag);

  assign sd64    = {{(W - SDW){sd[SDW-1]}}, sd};
  assign sr64    = {{(W - SDW){sr[SDW-1]}}, sr};
  assign sd_mag  = W'(sd[SDW-1] ? (SDW'(0) - sd) : sd);
  assign n64     = W'(template_count);
  assign num_mag = num[W-1] ? (W'(0) - num) : num;

  // saturated Q1.15 coefficient and the pick rule
  always_comb begin
    if (zero_c) begin
      coef = '0;
    end else if (num[W-1]) begin
      coef = (q_val >= W'(32768)) ? nxcpl_pkg::COEF_MIN : (CW'(0) - q_val[CW-1:0]);
    end else begin
      coef = (q_val > W'(32767)) ? nxcpl_pkg::COEF_MAX : q_val[CW-1:0];
    end
    abs_c    = coef[CW-1] ? ((CW + 1)'(0) - {coef[CW-1], coef}) : {1'b0, coef};
    abs_best = best[CW-1] ? ((CW + 1)'(0) - {best[CW-1], best}) : {1'b0, best};
    better   = allow_anti ? (abs_c > abs_best) : (coef > best);
  end

  // sequencer
  always_comb begin
    state_next = state;
    req.start  = 1'b0;
    req.op     = nxcpl_pkg::OP_MUL;
    req.neg    = 1'b0;
    req.x      = '0;
    req.y      = '0;
    s_tready   = (state == nxcpl_pkg::S_IDLE);
    unique case (state)
      nxcpl_pkg::S_IDLE: begin
        if (in_fire && s_tuser == nxcpl_pkg::CMD_TRACE && s_tlast) state_next = nxcpl_pkg::S_START;
      end
      nxcpl_pkg::S_START: begin
        state_next = can_search ? nxcpl_pkg::S_MAC : nxcpl_pkg::S_EMIT;
      end
      nxcpl_pkg::S_MAC: begin
        if (mac_done) state_next = nxcpl_pkg::S_MUL_A1;
      end
      nxcpl_pkg::S_MUL_A1: begin
        req.x = sdd;
        req.y = n64;
        if (rsp.done) state_next = nxcpl_pkg::S_MUL_A2;
      end
      nxcpl_pkg::S_MUL_A2: begin
        req.x   = sd64;
        req.y   = sd_mag;
        req.neg = sd[SDW-1];
        if (rsp.done) state_next = nxcpl_pkg::S_SQRT;
      end
      nxcpl_pkg::S_SQRT: begin
        req.op = nxcpl_pkg::OP_SQRT;
        req.x  = a_val;
        if (rsp.done) state_next = pre ? nxcpl_pkg::S_MAC : nxcpl_pkg::S_MUL_N1;
      end
      nxcpl_pkg::S_MUL_N1: begin
        req.x = sdr;
        req.y = n64;
        if (rsp.done) state_next = nxcpl_pkg::S_MUL_N2;
      end
      nxcpl_pkg::S_MUL_N2: begin
        req.x   = sr64;
        req.y   = sd_mag;
        req.neg = sd[SDW-1];
        if (rsp.done) begin
          state_next = (sa == '0 || sb == '0) ? nxcpl_pkg::S_CMP : nxcpl_pkg::S_DIV1;
        end
      end
      nxcpl_pkg::S_DIV1: begin
        req.op = nxcpl_pkg::OP_DIV;
        req.x  = num_mag << nxcpl_pkg::Q_SHIFT;
        req.y  = W'(sa);
        if (rsp.done) state_next = nxcpl_pkg::S_DIV2;
      end
      nxcpl_pkg::S_DIV2: begin
        req.op = nxcpl_pkg::OP_DIV;
        req.x  = q_val;
        req.y  = W'(sb);
        if (rsp.done) state_next = nxcpl_pkg::S_CMP;
      end
      nxcpl_pkg::S_CMP: begin
        state_next = last_lag ? nxcpl_pkg::S_EMIT : nxcpl_pkg::S_MAC;
      end
      nxcpl_pkg::S_EMIT: begin
        if (emit_go) state_next = nxcpl_pkg::S_IDLE;
      end
      default: state_next = nxcpl_pkg::S_IDLE;
    endcase
    if (!launched && (state == nxcpl_pkg::S_MUL_A1 || state == nxcpl_pkg::S_MUL_A2 ||
        state == nxcpl_pkg::S_SQRT || state == nxcpl_pkg::S_MUL_N1 ||
        state == nxcpl_pkg::S_MUL_N2 || state == nxcpl_pkg::S_DIV1 ||
        state == nxcpl_pkg::S_DIV2)) begin
      req.start = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= nxcpl_pkg::S_IDLE;
    else     state <= state_next;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      allow_anti     <= 1'b0;
      template_count <= '0;
      trace_count    <= '0;
      template_done  <= 1'b0;
      overflow_flag  <= 1'b0;
      launched       <= 1'b0;
      pre            <= 1'b0;
      it             <= '0;
      v1             <= 1'b0;
      v2             <= 1'b0;
      lag            <= '0;
      lag_end        <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) allow_anti <= cfg_data;
      if (req.start)     launched <= 1'b1;
      else if (rsp.done) launched <= 1'b0;
      v1 <= issue;
      v2 <= v1;
      if (mac_clear)  it <= '0;
      else if (issue) it <= it + 1'b1;
      if (in_fire) begin
        if (s_tuser == nxcpl_pkg::CMD_TEMPLATE) begin
          if (template_done) overflow_flag <= 1'b0;
          if (tc_eff < TCW'(TEMPLATE_MAX)) template_count <= tc_eff + 1'b1;
          else begin
            template_count <= tc_eff;
            overflow_flag  <= 1'b1;
          end
          template_done <= s_tlast;
        end else begin
          if (trace_count < RCW'(TRACE_MAX)) trace_count <= trace_count + 1'b1;
          else overflow_flag <= 1'b1;
        end
      end
      if (state == nxcpl_pkg::S_START) begin
        pre     <= 1'b1;
        lag     <= '0;
        lag_end <= RCW'(AW'(trace_count) - AW'(template_count));
      end
      if (state == nxcpl_pkg::S_SQRT && rsp.done) pre <= 1'b0;
      if (state == nxcpl_pkg::S_CMP) lag <= lag + 1'b1;
      if (emit_go)                   m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (emit_go) begin
        trace_count   <= '0;
        overflow_flag <= 1'b0;
      end
    end
  end

  // sample stores, registered reads
  always_ff @(posedge clk) begin
    if (in_fire && s_tuser == nxcpl_pkg::CMD_TEMPLATE && tc_eff < TCW'(TEMPLATE_MAX)) begin
      tmpl_mem[tc_eff[TAW-1:0]] <= s_tdata[SAMPLE_BITS-1:0];
    end
    tmpl_q <= tmpl_mem[it[TAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (in_fire && s_tuser == nxcpl_pkg::CMD_TRACE && trace_count < RCW'(TRACE_MAX)) begin
      trace_mem[trace_count[RAW-1:0]] <= s_tdata[SAMPLE_BITS-1:0];
    end
    trace_q <= trace_mem[trace_addr[RAW-1:0]];
  end

  // the template sums reuse the window path with the template on both inputs
  assign d_s = pre ? tmpl_q : trace_q;

  always_ff @(posedge clk) begin
    p_dd <= d_s * d_s;
    p_dr <= d_s * $signed(tmpl_q);
    d2   <= d_s;
    if (mac_clear) begin
      sd  <= '0;
      sdd <= '0;
      sdr <= '0;
    end else if (v2) begin
      sd  <= sd + {{(SDW - SAMPLE_BITS){d2[SAMPLE_BITS-1]}}, d2};
      sdd <= sdd + {{(W - PW){p_dd[PW-1]}}, p_dd};
      sdr <= sdr + {{(W - PW){p_dr[PW-1]}}, p_dr};
    end
    if (rsp.done) begin
      unique case (state)
        nxcpl_pkg::S_MUL_A1: tmp   <= rsp.result;
        nxcpl_pkg::S_MUL_A2: a_val <= tmp - rsp.result;
        nxcpl_pkg::S_SQRT: begin
          if (pre) begin
            sb <= rsp.result[RW-1:0];
            sr <= sd;
          end else begin
            sa <= rsp.result[RW-1:0];
          end
        end
        nxcpl_pkg::S_MUL_N1: tmp <= rsp.result;
        nxcpl_pkg::S_MUL_N2: begin
          num    <= tmp - rsp.result;
          zero_c <= (sa == '0 || sb == '0);
        end
        nxcpl_pkg::S_DIV1: q_val <= rsp.result;
        nxcpl_pkg::S_DIV2: q_val <= rsp.result;
        default: tmp <= tmp;
      endcase
    end
    if (state == nxcpl_pkg::S_START) begin
      best     <= '0;
      best_lag <= '0;
    end else if (state == nxcpl_pkg::S_CMP && better) begin
      best     <= coef;
      best_lag <= lag;
    end
    if (emit_go) begin
      m_tdata <= {{(nxcpl_pkg::OUT_W - nxcpl_pkg::LAG_W - CW){1'b0}}, best,
                  nxcpl_pkg::LAG_W'(best_lag)};
      m_tuser <= overflow_flag;
    end
  end

  nxcpl_iter_unit u_iter (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  `include "normalized_xcorr_peak_lag_core_assert.svh"

  `NXCPL_ASSERT_IMP(a_cmp_lag, state == nxcpl_pkg::S_CMP, lag < lag_end, "lag beyond range")
  `NXCPL_ASSERT_IMP(a_mac_quiet, state == nxcpl_pkg::S_MAC, !launched, "unit busy during sums")
  `NXCPL_ASSERT_NXT(a_emit, emit_go, m_tvalid && trace_count == '0, "result beat not loaded")

endmodule

// File: tb/sv/normalized_xcorr_peak_lag_core_checker.sv
// checker for the correlation peak search: watches the streams, predicts each peak, compares
`timescale 1ns / 100ps
module normalized_xcorr_peak_lag_core_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,   // sample
  input  logic        s_tuser,   // command
  input  logic        s_tlast,   // last
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // best_lag, best_coeff
  input  logic        m_tuser,   // overflow
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_data,  // allow_anti
  output int          errors,
  output int          pending
);

  localparam int TMPL_DEPTH  = 256;
  localparam int TRACE_DEPTH = 4096;

  typedef struct packed {
    logic [11:0] lag;
    logic [15:0] coeff;
    logic        ovf;
  } peak_t;

  longint unsigned tmpl_mem [TMPL_DEPTH];
  longint unsigned trace_mem[TRACE_DEPTH];
  int   tmpl_len, trace_len;
  logic tmpl_ready, ovf_seen, anti_mode;
  peak_t peak_q[$];

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic int q15_coeff(longint unsigned num, longint unsigned a,
                                   longint unsigned b);
    longint unsigned sa, sb, mag, q;
    logic neg;
    sa = floor_root(a);
    sb = floor_root(b);
    neg = num[63];
    mag = neg ? -num : num;
    if (sa == 0 || sb == 0) return 0;
    q = ((mag << 15) / sa) / sb;
    if (neg) return (q >= 32768) ? -32768 : -int'(q);
    return (q > 32767) ? 32767 : int'(q);
  endfunction

  function automatic peak_t find_peak();
    peak_t p;
    longint unsigned un, sr, srr, nb, sd, sdd, sdr, na, num;
    int best, c, best_at;
    p = '0;
    p.ovf = ovf_seen;
    if (!tmpl_ready || tmpl_len == 0 || trace_len <= tmpl_len) return p;
    un = tmpl_len;
    sr = 0;
    srr = 0;
    for (int i = 0; i < tmpl_len; i++) begin
      sr += tmpl_mem[i];
      srr += tmpl_mem[i] * tmpl_mem[i];
    end
    nb = un * srr - sr * sr;
    best = 0;
    best_at = 0;
    for (int l = 0; l < trace_len - tmpl_len; l++) begin
      sd = 0;
      sdd = 0;
      sdr = 0;
      for (int i = 0; i < tmpl_len; i++) begin
        sd += trace_mem[l+i];
        sdd += trace_mem[l+i] * trace_mem[l+i];
        sdr += trace_mem[l+i] * tmpl_mem[i];
      end
      na = un * sdd - sd * sd;
      num = un * sdr - sd * sr;
      c = q15_coeff(num, na, nb);
      if ((anti_mode && (c < 0 ? -c : c) > (best < 0 ? -best : best)) ||
          (!anti_mode && c > best)) begin
        best = c;
        best_at = l;
      end
    end
    p.lag = best_at[11:0];
    p.coeff = best[15:0];
    return p;
  endfunction

  always @(posedge clk) begin
    peak_t want;
    logic signed [15:0] smp;
    if (rst) begin
      tmpl_len = 0;
      trace_len = 0;
      tmpl_ready = 1'b0;
      ovf_seen = 1'b0;
      anti_mode = 1'b0;
      peak_q.delete();
      errors = 0;
    end else begin
      // results first: a beat can never answer an input of the same edge
      if (m_tvalid && m_tready) begin
        if (peak_q.size() == 0) begin
          $display("%0t: unexpected result lag=%0d coeff=%0d ovf=%0d", $time,
                   m_tdata[11:0], $signed(m_tdata[27:12]), m_tuser);
          errors++;
        end else begin
          want = peak_q.pop_front();
          if (m_tdata[11:0] !== want.lag) begin
            $display("%0t: best_lag expected %0d actual %0d", $time, want.lag, m_tdata[11:0]);
            errors++;
          end
          if (m_tdata[27:12] !== want.coeff) begin
            $display("%0t: best_coeff expected %0d actual %0d", $time,
                     $signed(want.coeff), $signed(m_tdata[27:12]));
            errors++;
          end
          if (m_tuser !== want.ovf) begin
            $display("%0t: overflow expected %0d actual %0d", $time, want.ovf, m_tuser);
            errors++;
          end
          if (m_tdata[31:28] !== 4'h0) begin
            $display("%0t: pad bits expected 0 actual %h", $time, m_tdata[31:28]);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) anti_mode = cfg_data;
      if (s_tvalid && s_tready) begin
        smp = s_tdata;
        if (s_tuser == nxcpl_pkg::CMD_TEMPLATE) begin
          if (tmpl_ready) begin
            tmpl_ready = 1'b0;
            tmpl_len = 0;
            ovf_seen = 1'b0;
          end
          if (tmpl_len < TMPL_DEPTH) begin
            tmpl_mem[tmpl_len] = smp;
            tmpl_len++;
          end else begin
            ovf_seen = 1'b1;
          end
          if (s_tlast) tmpl_ready = 1'b1;
        end else begin
          if (trace_len < TRACE_DEPTH) begin
            trace_mem[trace_len] = smp;
            trace_len++;
          end else begin
            ovf_seen = 1'b1;
          end
          if (s_tlast) begin
            peak_q.push_back(find_peak());
            trace_len = 0;
            ovf_seen = 1'b0;
          end
        end
      end
    end
    pending = peak_q.size();
  end
endmodule

// File: tb/sv/normalized_xcorr_peak_lag_core_tb.sv
// top of the correlation peak search bench: stimulus, receiver stalls, watchdog, verdict
`timescale 1ns / 100ps
module normalized_xcorr_peak_lag_core_tb;

  localparam int WATCHDOG_LIMIT = 400000;
  localparam int LONG_HOLD      = 3000;
  localparam int ITEM_TARGET    = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // sample
  logic        s_tuser = 1'b0; // command
  logic        s_tlast = 1'b0; // last
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // best_lag, best_coeff
  logic        m_tuser;        // overflow
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0; // allow_anti
  int          errors, pending;

  int   burst_left = 0;
  int   beats_sent = 0;
  logic hold_req = 1'b0;
  int   idle_cycles = 0;
  int   tmpl_copy[$];

  always #10 clk = ~clk;

  normalized_xcorr_peak_lag_core i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  normalized_xcorr_peak_lag_core_checker i_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  // receiver: stall pattern redrawn at random at the start of each phase, plus one long hold on request
  always @(negedge clk) begin
    int mode, phase_cnt, hold_cnt;
    logic hold_taken;
    if (rst) begin
      m_tready <= 1'b0;
      phase_cnt = 0;
      hold_cnt = 0;
      mode = 0;
      hold_taken = 1'b0;
    end else begin
      if (hold_req && !hold_taken) begin
        hold_cnt = LONG_HOLD;
        hold_taken = 1'b1;
      end
      if (phase_cnt == 0) begin
        mode = $urandom_range(0, 2);
        phase_cnt = 64;
      end
      phase_cnt--;
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // watchdog: cycles with no beat on any channel
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("normalized_xcorr_peak_lag_core_tb failed");
      $finish;
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_beat(logic cmd, int val, logic fin);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= val[15:0];
    s_tlast <= fin;
    do @(posedge clk); while (!s_tready);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_template(int vals[$]);
    tmpl_copy = vals;
    foreach (vals[i]) send_beat(nxcpl_pkg::CMD_TEMPLATE, vals[i], i == vals.size() - 1);
  endtask

  task automatic send_trace(int vals[$]);
    foreach (vals[i]) send_beat(nxcpl_pkg::CMD_TRACE, vals[i], i == vals.size() - 1);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_anti(logic v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic int pick_sample(int kind);
    case (kind)
      0: return $signed(16'($urandom()));
      1: return $urandom_range(0, 1) ? 32767 : -32768;
      2: return $urandom_range(0, 6) - 3;
      default: return 100;
    endcase
  endfunction

  function automatic int clamp16(int v);
    return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
  endfunction

  initial begin
    int seq[$];
    int n, len, kind, off, sgn, scale;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    write_anti(1'b0);

    // trace while no template is loaded: result is all zero
    send_trace('{3, -7, 11, 0, 5, 9});

    // extremes, a template with an anti-correlated window
    send_template('{32767, -32768, 0, 1});
    send_trace('{5, 32767, -32768, 0, 1, -32767, 32767, -1});
    // trace no longer than the template
    send_trace('{1, 2, 3, 4});
    // template beats arriving in the middle of a trace restart the template
    send_beat(nxcpl_pkg::CMD_TRACE, 7, 1'b0);
    send_beat(nxcpl_pkg::CMD_TEMPLATE, -5, 1'b0);
    send_beat(nxcpl_pkg::CMD_TEMPLATE, 9, 1'b1);
    send_trace('{-9, 5, 9, -5, 0});
    // constant trace gives a zero norm, single-sample template too
    send_trace('{100, 100, 100, 100});
    send_template('{3});
    send_trace('{1, 2, 3});
    wait_idle();
    write_anti(1'b1);
    send_template('{1, 2, 3});
    send_trace('{-1, -2, -3, 0, 1, 2, 3});

    // template overflow: extra beats are dropped and flagged
    seq = {};
    for (int i = 0; i < 260; i++) seq.push_back(pick_sample(0));
    send_template(seq);
    seq = {};
    for (int i = 0; i < 258; i++) seq.push_back(pick_sample(0));
    send_trace(seq);

    while (beats_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 5) == 0) begin
        wait_idle();
        write_anti(1'($urandom_range(0, 1)));
      end
      if (!hold_req && beats_sent > 1000 && beats_sent < 1100) hold_req = 1'b1;
      // a new template now and then
      if (tmpl_copy.size() == 0 || $urandom_range(0, 2) == 0) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(2, 16);
        kind = $urandom_range(0, 4);
        seq = {};
        for (int i = 0; i < n; i++) seq.push_back(pick_sample(kind > 3 ? 0 : kind));
        send_template(seq);
      end
      n = tmpl_copy.size();
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, n + 1) : n + $urandom_range(1, 30);
      kind = $urandom_range(0, 4);
      seq = {};
      for (int i = 0; i < len; i++) seq.push_back(pick_sample(kind > 3 ? 0 : kind));
      // plant a scaled, possibly negated copy of the template
      if ($urandom_range(0, 2) != 0 && len > n) begin
        off = $urandom_range(0, len - n - 1);
        sgn = $urandom_range(0, 1) ? 1 : -1;
        scale = $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
          seq[off+i] = clamp16(sgn * tmpl_copy[i] / scale + int'($urandom_range(0, 4)) - 2);
      end
      // broken sequence: template beat in the middle of the trace
      if ($urandom_range(0, 15) == 0) begin
        send_beat(nxcpl_pkg::CMD_TRACE, seq[0], 1'b0);
        send_beat(nxcpl_pkg::CMD_TEMPLATE, pick_sample(0), 1'($urandom_range(0, 1)));
      end
      send_trace(seq);
    end

    wait_idle();
    if (errors == 0 && pending == 0)
      $display("normalized_xcorr_peak_lag_core_tb passed");
    else
      $display("normalized_xcorr_peak_lag_core_tb failed");
    $finish;
  end
endmodule

// File: normalized_xcorr_peak_lag_core.f
+incdir+sv
sv/nxcpl_pkg.sv
sv/nxcpl_iter_unit.sv
sv/normalized_xcorr_peak_lag_core.sv
tb/sv/normalized_xcorr_peak_lag_core_checker.sv
tb/sv/normalized_xcorr_peak_lag_core_tb.sv
